/* rtl/apm_pkg.sv */
package apm_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int CHANNELS_W = 4;

  // register reset value
  localparam logic [CHANNELS_W-1:0] CHANNELS_RESET = CHANNELS_W'(2);

  // default sizing
  localparam int BUFFER_SAMPLES_DEF = 4096;
  localparam int MAX_CHANNELS_DEF   = 8;

  // halve a signed sample, truncating toward zero
  function automatic logic signed [SAMPLE_W-1:0] half_toward_zero(
    input logic signed [SAMPLE_W-1:0] x
  );
    logic signed [SAMPLE_W-1:0] t;
    t = x + $signed({{(SAMPLE_W-1){1'b0}}, x[SAMPLE_W-1]});
    return t >>> 1;
  endfunction

endpackage

/* rtl/apm_ram.sv */
module apm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/averaging_playback_mixer_unit.sv */
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+-----------------------------
// request   | req_type, sample_value, clip_first              | start, taken when busy low
// result    | sample_out, frame_last, underrun, dropped       | result_strobe, one cycle
// config    | cfg_data (channels)                             | cfg_we, no wait
//
// a clip sample that mixes reads the entry, then averages and writes it back
// an appended or dropped clip sample needs no read; a frame request reads its played samples
// (up to channels) one at a time through the single read port of the sample ram
// a result shows in the cycle after the accepting edge, after the read edge for a played
// sample, and after the write-back edge for a mixing clip sample
// synchronous reset clears pointers and counts; the sample ram needs no clearing
// the receiver cannot stall, so results never wait
module averaging_playback_mixer_unit
  import apm_pkg::*;
#(
  parameter int BUFFER_SAMPLES = BUFFER_SAMPLES_DEF,
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic                       clip_first,
  output logic                       result_strobe,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       frame_last,
  output logic                       underrun,
  output logic                       dropped,
  input  logic                       cfg_we,
  input  logic [CHANNELS_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(BUFFER_SAMPLES);
  localparam int CNT_W  = $clog2(BUFFER_SAMPLES + 1);
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CHC_W  = (CH_W > CHANNELS_W) ? CH_W : CHANNELS_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_SAMPLES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_SAMPLES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MIX  = 3'b010,
    S_PLAY = 3'b100
  } state_t;

  state_t state;
  logic [CHANNELS_W-1:0] channels;
  logic [IDX_W-1:0] read_index;
  logic [IDX_W-1:0] tail_index;
  logic [IDX_W-1:0] mix_index;
  logic [CNT_W-1:0] pending_count;
  logic [CNT_W-1:0] mix_remaining;
  logic [IDX_W-1:0] mix_addr;
  logic signed [SAMPLE_W-1:0] val_half;
  logic [CH_W-1:0] play_left;
  logic res_from_ram;

  logic accept, is_clip, is_frame;
  logic mix_go, app_go, drop_go, play_first, play_issue, play_last;
  logic [IDX_W-1:0] eff_mix_index;
  logic [CNT_W-1:0] eff_remaining;
  logic [IDX_W-1:0] read_next, tail_next, mix_next;
  logic [CNT_W-1:0] pending_next;
  logic [CHC_W-1:0] ch_wide;
  logic [CH_W-1:0] ch_eff, frame_n;
  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic signed [SAMPLE_W-1:0] mixed;

  // request decode
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_clip  = accept && !req_type;
  assign is_frame = accept && req_type;

  assign eff_mix_index = clip_first ? read_index : mix_index;
  assign eff_remaining = clip_first ? pending_count : mix_remaining;

  assign mix_go     = is_clip && (eff_remaining != '0);
  assign app_go     = is_clip && (eff_remaining == '0) && (pending_count != FULL_CNT);
  assign drop_go    = is_clip && (eff_remaining == '0) && (pending_count == FULL_CNT);
  assign play_first = is_frame && (pending_count != '0);
  assign play_issue = play_first || (state == S_PLAY);

  // ring successors
  assign read_next = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
  assign tail_next = (tail_index == LAST_IDX) ? '0 : tail_index + 1'b1;
  assign mix_next  = (eff_mix_index == LAST_IDX) ? '0 : eff_mix_index + 1'b1;
  assign pending_next = pending_count - 1'b1;

  // effective channel count and frame length
  always_comb begin
    ch_wide = CHC_W'(channels);
    if (ch_wide == '0) begin
      ch_wide = CHC_W'(1);
    end else if (ch_wide > CHC_W'(MAX_CHANNELS)) begin
      ch_wide = CHC_W'(MAX_CHANNELS);
    end
    ch_eff = CH_W'(ch_wide);
    if (pending_count < CNT_W'(ch_eff)) begin
      frame_n = CH_W'(pending_count);
    end else begin
      frame_n = ch_eff;
    end
  end

  assign play_last = (state == S_PLAY) ? (play_left == CH_W'(1)) : (frame_n == CH_W'(1));

  // average of stored and new sample
  assign mixed = half_toward_zero($signed(ram_rdata)) + val_half;

  // sample ram ports
  assign ram_re    = mix_go || play_issue;
  assign ram_raddr = mix_go ? eff_mix_index : read_index;
  assign ram_we    = app_go || (state == S_MIX);
  assign ram_waddr = (state == S_MIX) ? mix_addr : tail_index;
  assign ram_wdata = (state == S_MIX) ? mixed : sample_value;

  apm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sample_out = res_from_ram ? $signed(ram_rdata) : '0;

  // channels register
  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= CHANNELS_RESET;
    end else if (cfg_we) begin
      channels <= cfg_data;
    end
  end

  // mix payload
  always_ff @(posedge clk) begin
    if (mix_go) begin
      mix_addr <= eff_mix_index;
      val_half <= half_toward_zero(sample_value);
    end
  end

  // control, pointers and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_index    <= '0;
      tail_index    <= '0;
      mix_index     <= '0;
      pending_count <= '0;
      mix_remaining <= '0;
      play_left     <= '0;
      result_strobe <= 1'b0;
      res_from_ram  <= 1'b0;
      frame_last    <= 1'b0;
      underrun      <= 1'b0;
      dropped       <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      res_from_ram  <= 1'b0;
      frame_last    <= 1'b0;
      underrun      <= 1'b0;
      dropped       <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (mix_go) begin
            mix_index     <= mix_next;
            mix_remaining <= eff_remaining - 1'b1;
            state         <= S_MIX;
          end else if (app_go) begin
            tail_index    <= tail_next;
            pending_count <= pending_count + 1'b1;
            mix_index     <= tail_next;
            mix_remaining <= '0;
            result_strobe <= 1'b1;
            frame_last    <= 1'b1;
          end else if (drop_go) begin
            result_strobe <= 1'b1;
            frame_last    <= 1'b1;
            dropped       <= 1'b1;
          end else if (is_frame && !play_first) begin
            result_strobe <= 1'b1;
            frame_last    <= 1'b1;
            underrun      <= 1'b1;
          end
          if (play_first) begin
            play_left <= frame_n - 1'b1;
            state     <= play_last ? S_IDLE : S_PLAY;
          end
        end
        S_MIX: begin
          result_strobe <= 1'b1;
          frame_last    <= 1'b1;
          state         <= S_IDLE;
        end
        S_PLAY: begin
          play_left <= play_left - 1'b1;
          if (play_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // one sample played per issued read
      if (play_issue) begin
        read_index    <= read_next;
        pending_count <= pending_next;
        result_strobe <= 1'b1;
        res_from_ram  <= 1'b1;
        frame_last    <= play_last;
        if (mix_remaining > pending_next) begin
          mix_index     <= read_next;
          mix_remaining <= pending_next;
        end
      end
    end
  end

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= FULL_CNT)
    else $error("pending count beyond buffer size");

  a_mix_within_pending: assert property (@(posedge clk) disable iff (rst)
    mix_remaining <= pending_count)
    else $error("mix window exceeds pending data");

  a_mix_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |-> $past(mix_go))
    else $error("mix write without a mixing clip transaction");

  a_underrun_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && underrun) |-> (frame_last && !dropped && !res_from_ram))
    else $error("underrun result malformed");

  a_no_ram_collision: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write of the same entry in one cycle");

endmodule
